// ===== hw/rtl/rlrv_pkg.sv =====
// Shared types and constants for the rolling log-return volatility block.
// Used by rlrv_ctrl, rlrv_dp and the top level; depends on nothing.
package rlrv_pkg;

    localparam int MAX_WINDOW_DEFAULT = 64;
    localparam int PRICE_W            = 32;
    localparam int VOL_W              = 32;
    localparam int USED_W             = 7;
    localparam int WIN_W              = 7;
    localparam int OUT_W              = 40;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd20;
    localparam logic [29:0]      LN2_Q30      = 30'd744261118;
    localparam int               ANNUAL_DAYS  = 252;
    localparam logic [5:0]       LOG_FRAC_BITS = 6'd28;
    localparam logic [5:0]       SQRT_STEPS    = 6'd32;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE, S_NORM, S_SQ_MUL, S_SQ_ACC, S_LOGDIFF, S_RET_MUL, S_RET_WR,
        S_COUNT, S_CHECK, S_SUM_RD, S_SUM_ACC, S_MEAN_START, S_MEAN_WAIT,
        S_DEV_RD, S_DEV_SUB, S_DEV_MUL, S_DEV_ACC, S_VAR_START, S_VAR_WAIT,
        S_SCALE, S_SQRT_INIT, S_SQRT_STEP, S_OUT
    } state_t;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_NORM, OP_SQ_MUL, OP_SQ_ACC, OP_LOGDIFF, OP_RET_MUL,
        OP_RET_WR, OP_COUNT, OP_SUM_ACC, OP_MEAN_START, OP_MEAN_WAIT,
        OP_DEV_SUB, OP_DEV_MUL, OP_DEV_ACC, OP_VAR_START, OP_VAR_WAIT,
        OP_SCALE, OP_SQRT_INIT, OP_SQRT_STEP, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic norm_done;
        logic have_prev;
        logic count_lt2;
        logic elem_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== hw/rtl/rlrv_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on nothing; instantiated by rlrv_dp.
module rlrv_div #(
    parameter int DW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [63:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [63:0]   quotient
);

    logic [63:0]   qd_reg, qd_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] dsr_reg;
    logic [6:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   rem_sh;

    // load on start, else one shift-subtract step while busy
    always_comb begin
        rem_sh    = {rem_reg[DW-1:0], qd_reg[63]};
        qd_next   = {qd_reg[62:0], 1'b0};
        rem_next  = rem_sh;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            qd_next   = dividend;
            rem_next  = '0;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dsr_reg}) begin
                rem_next   = rem_sh - {1'b0, dsr_reg};
                qd_next[0] = 1'b1;
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else begin
            qd_next  = qd_reg;
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

// ===== hw/rtl/rlrv_dp.sv =====
// Datapath: log2 by squaring, return ring, sums, variance, square root, output register.
// Depends on rlrv_pkg and rlrv_div.
module rlrv_dp #(
    parameter int MAX_WINDOW = rlrv_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rlrv_pkg::cmd_t                cmd,
    output rlrv_pkg::status_t             status,
    input  logic [rlrv_pkg::PRICE_W-1:0]  s_tdata,
    input  logic                          cfg_valid,
    input  logic [rlrv_pkg::WIN_W-1:0]    cfg_data,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [rlrv_pkg::OUT_W-1:0]    m_tdata
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int SW = 31 + CW;
    localparam logic [63:0] VAR_LIMIT = (64'd1 << 60) / 64'(rlrv_pkg::ANNUAL_DAYS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WINDOW - 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_WINDOW);

    // control state
    logic [rlrv_pkg::WIN_W-1:0] window_reg;
    logic                       have_prev_reg;
    logic [AW-1:0]              pos_reg;
    logic [CW-1:0]              stored_reg;
    logic                       m_tvalid_reg;

    // payload state
    logic [31:0]            m_reg;
    logic [4:0]             e_reg;
    logic [27:0]            f_reg;
    logic [63:0]            prod_reg;
    logic                   clamp_reg;
    logic [32:0]            prev_log_reg;
    logic                   neg_reg;
    logic [32:0]            mag_reg;
    logic [62:0]            rprod_reg;
    logic [30:0]            ring [MAX_WINDOW];
    logic [CW-1:0]          count_reg;
    logic                   zero_vol_reg;
    logic [AW-1:0]          rd_ptr_reg;
    logic [30:0]            rd_data_reg;
    logic [CW-1:0]          elem_reg;
    logic signed [SW-1:0]   sum_reg;
    logic signed [30:0]     mean_reg;
    logic [31:0]            ad_reg;
    logic [63:0]            sq_reg;
    logic [63:0]            var_reg;
    logic                   sat_reg;
    logic [60:0]            t_reg;
    logic [63:0]            v_reg, res_reg, bit_reg;
    logic                   vol_sat_reg;
    logic [rlrv_pkg::OUT_W-1:0] m_tdata_reg;

    // combinational helpers
    logic [31:0]          price_c;
    logic [32:0]          lc;
    logic [32:0]          sq_top;
    logic [63:0]          rnd;
    logic [29:0]          r_mag;
    logic [30:0]          ret_val;
    logic [CW-1:0]        win_c, stored_inc, count_c;
    logic [AW-1:0]        pos_inc, ptr_last;
    logic [SW-1:0]        sum_abs;
    logic                 sum_neg;
    logic signed [32:0]   dv;
    logic [64:0]          sq_sum;
    logic [64:0]          rb;
    logic [63:0]          div_dividend;
    logic [CW-1:0]        div_divisor;
    logic                 div_start, div_done;
    logic [63:0]          div_q;
    logic [30:0]          q31;
    logic                 out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        price_c  = (s_tdata == '0) ? 32'd1 : s_tdata;
        lc       = {e_reg, f_reg};
        sq_top   = prod_reg[63:31];
        rnd      = 64'(rprod_reg) + (64'd1 << 33);
        r_mag    = rnd[63:34];
        ret_val  = neg_reg ? (31'd0 - 31'(r_mag)) : 31'(r_mag);
        // window register clamped to the legal range
        if (window_reg < 7'd2) begin
            win_c = CW'(2);
        end else if (32'(window_reg) > MAX_WINDOW) begin
            win_c = MAX_CNT;
        end else begin
            win_c = CW'(window_reg);
        end
        stored_inc = (stored_reg == MAX_CNT) ? stored_reg : stored_reg + CW'(1);
        count_c    = (stored_reg < win_c) ? stored_reg : win_c;
        pos_inc    = (pos_reg == LAST_ADDR) ? '0 : pos_reg + AW'(1);
        ptr_last   = (pos_reg == '0) ? LAST_ADDR : pos_reg - AW'(1);
        sum_neg    = sum_reg[SW-1];
        sum_abs    = sum_neg ? SW'(-sum_reg) : SW'(sum_reg);
        dv         = 33'($signed(rd_data_reg)) - 33'(mean_reg);
        sq_sum     = {1'b0, sq_reg} + {5'b0, prod_reg[63:4]};
        rb         = {1'b0, res_reg} + {1'b0, bit_reg};
        q31        = div_q[30:0];
        div_start  = (cmd.op == rlrv_pkg::OP_MEAN_START) || (cmd.op == rlrv_pkg::OP_VAR_START);
        div_dividend = (cmd.op == rlrv_pkg::OP_MEAN_START) ? 64'(sum_abs) : sq_reg;
        div_divisor  = (cmd.op == rlrv_pkg::OP_MEAN_START) ? count_reg : count_reg - CW'(1);
    end

    rlrv_div #(
        .DW (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= rlrv_pkg::WINDOW_RESET;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            stored_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                window_reg <= cfg_data;
            end
            if (cmd.op == rlrv_pkg::OP_LOGDIFF) begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.op == rlrv_pkg::OP_RET_WR) begin
                pos_reg    <= pos_inc;
                stored_reg <= stored_inc;
            end
            if (cmd.op == rlrv_pkg::OP_OUT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // return ring: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.op == rlrv_pkg::OP_RET_WR) begin
            ring[pos_reg] <= ret_val;
        end
        rd_data_reg <= ring[rd_ptr_reg];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            rlrv_pkg::OP_LOAD: begin
                m_reg        <= price_c;
                clamp_reg    <= (s_tdata == '0);
                e_reg        <= 5'd31;
                f_reg        <= '0;
                count_reg    <= '0;
                zero_vol_reg <= 1'b1;
            end
            rlrv_pkg::OP_NORM: begin
                if (!m_reg[31]) begin
                    m_reg <= {m_reg[30:0], 1'b0};
                    e_reg <= e_reg - 5'd1;
                end
            end
            rlrv_pkg::OP_SQ_MUL: begin
                prod_reg <= m_reg * m_reg;
            end
            rlrv_pkg::OP_SQ_ACC: begin
                if (sq_top[32]) begin
                    m_reg <= sq_top[32:1];
                    f_reg <= {f_reg[26:0], 1'b1};
                end else begin
                    m_reg <= sq_top[31:0];
                    f_reg <= {f_reg[26:0], 1'b0};
                end
            end
            rlrv_pkg::OP_LOGDIFF: begin
                neg_reg      <= lc < prev_log_reg;
                mag_reg      <= (lc < prev_log_reg) ? prev_log_reg - lc : lc - prev_log_reg;
                prev_log_reg <= lc;
            end
            rlrv_pkg::OP_RET_MUL: begin
                rprod_reg <= mag_reg * rlrv_pkg::LN2_Q30;
            end
            rlrv_pkg::OP_COUNT: begin
                count_reg    <= count_c;
                zero_vol_reg <= count_c < CW'(2);
                elem_reg     <= count_c;
                rd_ptr_reg   <= ptr_last;
                sum_reg      <= '0;
            end
            rlrv_pkg::OP_SUM_ACC: begin
                sum_reg    <= sum_reg + SW'($signed(rd_data_reg));
                elem_reg   <= elem_reg - CW'(1);
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - AW'(1);
            end
            rlrv_pkg::OP_MEAN_START: begin
                elem_reg   <= count_reg;
                rd_ptr_reg <= ptr_last;
                sq_reg     <= '0;
            end
            rlrv_pkg::OP_MEAN_WAIT: begin
                if (div_done) begin
                    mean_reg <= sum_neg ? $signed(31'd0 - q31) : $signed(q31);
                end
            end
            rlrv_pkg::OP_DEV_SUB: begin
                ad_reg <= dv[32] ? 32'(-dv) : 32'(dv);
            end
            rlrv_pkg::OP_DEV_MUL: begin
                prod_reg <= ad_reg * ad_reg;
            end
            rlrv_pkg::OP_DEV_ACC: begin
                sq_reg     <= sq_sum[64] ? '1 : sq_sum[63:0];
                elem_reg   <= elem_reg - CW'(1);
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_ADDR : rd_ptr_reg - AW'(1);
            end
            rlrv_pkg::OP_VAR_WAIT: begin
                if (div_done) begin
                    var_reg <= div_q;
                end
            end
            rlrv_pkg::OP_SCALE: begin
                sat_reg <= var_reg > VAR_LIMIT;
                t_reg   <= 61'(var_reg[52:0]) * 61'(rlrv_pkg::ANNUAL_DAYS);
            end
            rlrv_pkg::OP_SQRT_INIT: begin
                v_reg       <= {t_reg[59:0], 4'b0};
                res_reg     <= '0;
                bit_reg     <= 64'd1 << 62;
                vol_sat_reg <= sat_reg | t_reg[60];
            end
            rlrv_pkg::OP_SQRT_STEP: begin
                if ({1'b0, v_reg} >= rb) begin
                    v_reg   <= v_reg - rb[63:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            rlrv_pkg::OP_OUT: begin
                m_tdata_reg <= {clamp_reg, 7'(count_reg),
                                zero_vol_reg ? 32'd0 :
                                (vol_sat_reg ? 32'hFFFF_FFFF : res_reg[31:0])};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.norm_done = m_reg[31];
        status.have_prev = have_prev_reg;
        status.count_lt2 = count_reg < CW'(2);
        status.elem_last = elem_reg == CW'(1);
        status.div_done  = div_done;
        status.out_free  = out_free;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/rlrv_ctrl.sv =====
// Controller state machine that sequences the datapath for one price.
// Depends on rlrv_pkg.
module rlrv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rlrv_pkg::status_t status,
    output rlrv_pkg::cmd_t    cmd
);

    rlrv_pkg::state_t state_reg, state_next;
    logic [5:0]       cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rlrv_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and datapath command
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = rlrv_pkg::OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            rlrv_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = rlrv_pkg::OP_LOAD;
                    state_next = rlrv_pkg::S_NORM;
                end
            end
            rlrv_pkg::S_NORM: begin
                cmd.op = rlrv_pkg::OP_NORM;
                if (status.norm_done) begin
                    cnt_next   = rlrv_pkg::LOG_FRAC_BITS;
                    state_next = rlrv_pkg::S_SQ_MUL;
                end
            end
            rlrv_pkg::S_SQ_MUL: begin
                cmd.op     = rlrv_pkg::OP_SQ_MUL;
                state_next = rlrv_pkg::S_SQ_ACC;
            end
            rlrv_pkg::S_SQ_ACC: begin
                cmd.op   = rlrv_pkg::OP_SQ_ACC;
                cnt_next = cnt_reg - 6'd1;
                state_next = (cnt_reg == 6'd1) ? rlrv_pkg::S_LOGDIFF : rlrv_pkg::S_SQ_MUL;
            end
            rlrv_pkg::S_LOGDIFF: begin
                cmd.op     = rlrv_pkg::OP_LOGDIFF;
                state_next = status.have_prev ? rlrv_pkg::S_RET_MUL : rlrv_pkg::S_OUT;
            end
            rlrv_pkg::S_RET_MUL: begin
                cmd.op     = rlrv_pkg::OP_RET_MUL;
                state_next = rlrv_pkg::S_RET_WR;
            end
            rlrv_pkg::S_RET_WR: begin
                cmd.op     = rlrv_pkg::OP_RET_WR;
                state_next = rlrv_pkg::S_COUNT;
            end
            rlrv_pkg::S_COUNT: begin
                cmd.op     = rlrv_pkg::OP_COUNT;
                state_next = rlrv_pkg::S_CHECK;
            end
            rlrv_pkg::S_CHECK: begin
                state_next = status.count_lt2 ? rlrv_pkg::S_OUT : rlrv_pkg::S_SUM_RD;
            end
            rlrv_pkg::S_SUM_RD: begin
                state_next = rlrv_pkg::S_SUM_ACC;
            end
            rlrv_pkg::S_SUM_ACC: begin
                cmd.op     = rlrv_pkg::OP_SUM_ACC;
                state_next = status.elem_last ? rlrv_pkg::S_MEAN_START : rlrv_pkg::S_SUM_RD;
            end
            rlrv_pkg::S_MEAN_START: begin
                cmd.op     = rlrv_pkg::OP_MEAN_START;
                state_next = rlrv_pkg::S_MEAN_WAIT;
            end
            rlrv_pkg::S_MEAN_WAIT: begin
                cmd.op = rlrv_pkg::OP_MEAN_WAIT;
                if (status.div_done) begin
                    state_next = rlrv_pkg::S_DEV_RD;
                end
            end
            rlrv_pkg::S_DEV_RD: begin
                state_next = rlrv_pkg::S_DEV_SUB;
            end
            rlrv_pkg::S_DEV_SUB: begin
                cmd.op     = rlrv_pkg::OP_DEV_SUB;
                state_next = rlrv_pkg::S_DEV_MUL;
            end
            rlrv_pkg::S_DEV_MUL: begin
                cmd.op     = rlrv_pkg::OP_DEV_MUL;
                state_next = rlrv_pkg::S_DEV_ACC;
            end
            rlrv_pkg::S_DEV_ACC: begin
                cmd.op     = rlrv_pkg::OP_DEV_ACC;
                state_next = status.elem_last ? rlrv_pkg::S_VAR_START : rlrv_pkg::S_DEV_RD;
            end
            rlrv_pkg::S_VAR_START: begin
                cmd.op     = rlrv_pkg::OP_VAR_START;
                state_next = rlrv_pkg::S_VAR_WAIT;
            end
            rlrv_pkg::S_VAR_WAIT: begin
                cmd.op = rlrv_pkg::OP_VAR_WAIT;
                if (status.div_done) begin
                    state_next = rlrv_pkg::S_SCALE;
                end
            end
            rlrv_pkg::S_SCALE: begin
                cmd.op     = rlrv_pkg::OP_SCALE;
                state_next = rlrv_pkg::S_SQRT_INIT;
            end
            rlrv_pkg::S_SQRT_INIT: begin
                cmd.op     = rlrv_pkg::OP_SQRT_INIT;
                cnt_next   = rlrv_pkg::SQRT_STEPS;
                state_next = rlrv_pkg::S_SQRT_STEP;
            end
            rlrv_pkg::S_SQRT_STEP: begin
                cmd.op   = rlrv_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    state_next = rlrv_pkg::S_OUT;
                end
            end
            rlrv_pkg::S_OUT: begin
                if (status.out_free) begin
                    cmd.op     = rlrv_pkg::OP_OUT;
                    state_next = rlrv_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rlrv_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rolling_log_return_volatility.sv =====
// Rolling volatility of log returns: one closing price per request in, one result per request
// out. A price goes from acceptance to the result register through these steps: the accept,
// normalising and squaring (28 rounds on one 32x32 multiplier) for its log2, the return and the
// window count, a mean pass and a deviation pass through the return ring with its one write
// port and one registered read port, the two divisions on one shared 64-step divider, scaling
// and square root, and the output. With fewer than two returns the passes are skipped.
// The next price is taken once the previous one is done; a finished result waits in the
// output register meanwhile. window_length may only be written while no price is in flight.
// Depends on rlrv_pkg, rlrv_ctrl, rlrv_dp and rlrv_div.
module rolling_log_return_volatility #(
    parameter int MAX_WINDOW = rlrv_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [rlrv_pkg::PRICE_W-1:0] s_tdata,   // [31:0] close_price
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rlrv_pkg::WIN_W-1:0]   cfg_data,  // window_length
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rlrv_pkg::OUT_W-1:0]   m_tdata    // [31:0] volatility, [38:32] returns_used,
                                                    // [39] price_clamped
);

    rlrv_pkg::cmd_t    cmd;
    rlrv_pkg::status_t status;
    logic              cfg_ready_int;

    assign cfg_ready_int = 1'b1;
    assign cfg_ready     = cfg_ready_int;

    rlrv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rlrv_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready_int),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    // a request is taken only when idle, so ready drops straight after
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still busy");

    // window count never beyond the ring depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[38:32]) <= MAX_WINDOW))
        else $error("returns_used beyond window depth");

    // fewer than two returns must give zero volatility
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[38:32] < 7'd2)) |-> (m_tdata[31:0] == 32'd0))
        else $error("non-zero volatility with fewer than two returns");

endmodule
